@@ hdl/iem_pkg.sv @@
// ----------------------------------------------------------------------------
// iem_pkg
// Shared types and constants for the input event remapper.
// ----------------------------------------------------------------------------
package iem_pkg;

  localparam int unsigned MAP_ENTRIES_DEF = 64;
  localparam int unsigned MAX_RESULTS     = 64;
  localparam int unsigned CNT_W           = 7;

  localparam logic [31:0] ACTION_BASE = 32'h0001_0000;
  localparam logic [3:0]  HAT_NONE    = 4'd15;

  // Result kinds
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_STATE  = 2'd1;
  localparam logic [1:0] KIND_ACTION = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_PLAYER = 3'd0;
  localparam logic [2:0] REG_HAT    = 3'd1;
  localparam logic [2:0] REG_LEFT   = 3'd2;
  localparam logic [2:0] REG_RIGHT  = 3'd3;
  localparam logic [2:0] REG_UP     = 3'd4;
  localparam logic [2:0] REG_DOWN   = 3'd5;

  typedef struct packed {
    logic [3:0]  player;
    logic [31:0] hat_code;
    logic [15:0] left_mask;
    logic [15:0] right_mask;
    logic [15:0] up_mask;
    logic [15:0] down_mask;
  } cfg_t;

  // One queued item, tagged by the front end
  typedef struct packed {
    logic        is_load;
    logic        idx_ok;
    logic [5:0]  entry_index;
    logic        entry_enable;
    logic [31:0] source;
    logic [31:0] raw;
    logic [31:0] low;
    logic [31:0] high;
    logic [31:0] target;
  } item_t;

  // One map table record
  typedef struct packed {
    logic [31:0] source;
    logic [31:0] low;
    logic [31:0] high;
    logic [31:0] target;
    logic        seen;
    logic [31:0] last_value;
    logic [3:0]  out_value;
  } entry_t;

endpackage

@@ hdl/iem_front.sv @@
// ----------------------------------------------------------------------------
// iem_front
// Accepts items, tags loads and their index check, and queues them (2 deep).
// ----------------------------------------------------------------------------
module iem_front import iem_pkg::*; #(
  parameter int unsigned MAP_ENTRIES = MAP_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [5:0]  in_entry_index,
  input  logic        in_entry_enable,
  input  logic [31:0] in_source_button,
  input  logic [31:0] in_raw_value,
  input  logic [31:0] in_range_low,
  input  logic [31:0] in_range_high,
  input  logic [31:0] in_target_code,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t      q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  item_t      it;

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = q_r[rp_r];

  // Classify the incoming item
  always_comb begin
    it.is_load      = in_req_type;
    it.idx_ok       = ({26'd0, in_entry_index} < 32'(MAP_ENTRIES));
    it.entry_index  = in_entry_index;
    it.entry_enable = in_entry_enable;
    it.source       = in_source_button;
    it.raw          = in_raw_value;
    it.low          = in_range_low;
    it.high         = in_range_high;
    it.target       = in_target_code;
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= it;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

@@ hdl/iem_back.sv @@
// ----------------------------------------------------------------------------
// iem_back
// Executes queued items: table loads, event scan over the map, hat sequencing,
// held-mask updates and result delivery with a one-deep hold for the last flag.
// ----------------------------------------------------------------------------
module iem_back import iem_pkg::*; #(
  parameter int unsigned MAP_ENTRIES = MAP_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_player,
  output logic [31:0] out_code,
  output logic        out_pressed,
  output logic        out_last
);

  localparam int unsigned AW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_SCAN, S_EVAL, S_HAT, S_FIN} st_t;

  st_t              st_r;
  item_t            cur_r;
  logic [AW-1:0]    i_r;
  logic [MAP_ENTRIES-1:0] valid_r;
  entry_t           mem [MAP_ENTRIES];
  entry_t           rd_r;
  logic [15:0]      held_r;
  logic [CNT_W-1:0] cnt_r;
  logic [1:0]       step_r;
  logic [15:0]      hm_r [4];
  logic [3:0]       hon_r;
  logic             pend_v_r;
  logic [1:0]       pend_kind_r;
  logic [31:0]      pend_code_r;
  logic             pend_pr_r;
  logic             out_valid_r, out_pressed_r, out_last_r;
  logic [1:0]       out_kind_r;
  logic [31:0]      out_code_r;

  // Evaluation signals
  logic        is_last_i, match, inr, is_hat, is_act;
  logic [32:0] off;
  logic [3:0]  hcode, outv_nxt;
  logic        dxp, dxn, dyp, dyn;
  logic        em_v, em_pr, em_go;
  logic [1:0]  em_kind;
  logic [31:0] em_code;
  logic [15:0] held_nxt, am_mask;
  logic        am_on, am_go;
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  entry_t      mem_wd;

  assign is_last_i = (i_r == AW'(MAP_ENTRIES - 1));

  // Entry evaluation
  always_comb begin
    match  = (rd_r.source == cur_r.source) &&
             !(rd_r.seen && rd_r.last_value == cur_r.raw);
    inr    = ($signed(cur_r.raw) >= $signed(rd_r.low)) &&
             ($signed(cur_r.raw) <= $signed(rd_r.high));
    is_hat = (rd_r.target == cfg.hat_code);
    is_act = (rd_r.target >= ACTION_BASE);
    off    = {cur_r.raw[31], cur_r.raw} - {rd_r.low[31], rd_r.low};
    hcode  = (off[32:3] == 30'd0) ? {1'b0, off[2:0]} : HAT_NONE;
    dxp = 1'b0; dxn = 1'b0; dyp = 1'b0; dyn = 1'b0;
    if (hcode != HAT_NONE) begin
      dxp = (hcode >= 4'd1) && (hcode <= 4'd3);
      dxn = (hcode >= 4'd5);
      dyn = (hcode == 4'd0) || (hcode == 4'd1) || (hcode == 4'd7);
      dyp = (hcode >= 4'd3) && (hcode <= 4'd5);
    end
    if (is_hat) outv_nxt = hcode;
    else        outv_nxt = {3'd0, inr};
  end

  // Mask apply and result generation
  always_comb begin
    am_mask = 16'd0;
    am_on   = 1'b0;
    em_v    = 1'b0;
    em_kind = KIND_STATE;
    em_code = 32'd0;
    em_pr   = 1'b0;
    if (st_r == S_EVAL && match && !is_hat) begin
      if (is_act) begin
        em_v    = inr && (rd_r.out_value == 4'd0);
        em_kind = KIND_ACTION;
        em_code = rd_r.target;
      end else if (outv_nxt != rd_r.out_value) begin
        am_mask = rd_r.target[15:0];
        am_on   = inr;
      end
    end else if (st_r == S_HAT) begin
      am_mask = hm_r[step_r];
      am_on   = hon_r[step_r];
    end
    am_go    = (am_mask != 16'd0) &&
               (am_on ? ((held_r & am_mask) == 16'd0) : ((held_r & am_mask) != 16'd0));
    held_nxt = held_r;
    if (am_go) begin
      held_nxt = am_on ? (held_r | am_mask) : (held_r & ~am_mask);
      em_v     = 1'b1;
      em_kind  = KIND_STATE;
      em_code  = {16'd0, am_mask};
      em_pr    = am_on;
    end
  end

  // results beyond the per-item limit are dropped
  assign em_go = em_v && (cnt_r < CNT_W'(MAX_RESULTS));

  // Table write port
  always_comb begin
    mem_we = 1'b0;
    mem_wa = i_r;
    mem_wd = rd_r;
    if (st_r == S_LOAD) begin
      mem_we = cur_r.idx_ok;
      mem_wa = AW'(cur_r.entry_index);
      mem_wd.source     = cur_r.source;
      mem_wd.low        = cur_r.low;
      mem_wd.high       = cur_r.high;
      mem_wd.target     = cur_r.target;
      mem_wd.seen       = 1'b0;
      mem_wd.last_value = 32'd0;
      mem_wd.out_value  = 4'd0;
    end else if (st_r == S_EVAL && match) begin
      mem_we = 1'b1;
      mem_wd.seen       = 1'b1;
      mem_wd.last_value = cur_r.raw;
      // action: out of range clears, in range keeps a nonzero level
      if (is_act && !is_hat) begin
        if (!inr)                         mem_wd.out_value = 4'd0;
        else if (rd_r.out_value == 4'd0)  mem_wd.out_value = 4'd1;
        else                              mem_wd.out_value = rd_r.out_value;
      end else begin
        mem_wd.out_value = outv_nxt;
      end
    end
  end

  // Map table
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (st_r == S_SCAN) rd_r <= mem[i_r];
  end

  assign q_pop = (st_r == S_IDLE) && q_valid;

  // Sequencer, held mask and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      valid_r     <= '0;
      held_r      <= 16'd0;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      step_r      <= 2'd0;
    end else begin
      out_valid_r <= (em_go && pend_v_r) || (st_r == S_FIN);
      held_r      <= held_nxt;
      // buffer one result so the final one can carry last
      if (em_go) begin
        if (pend_v_r) begin
          out_kind_r    <= pend_kind_r;
          out_code_r    <= pend_code_r;
          out_pressed_r <= pend_pr_r;
          out_last_r    <= 1'b0;
        end
        pend_v_r    <= 1'b1;
        pend_kind_r <= em_kind;
        pend_code_r <= em_code;
        pend_pr_r   <= em_pr;
        cnt_r       <= cnt_r + 1'b1;
      end
      case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            cur_r <= q_item;
            i_r   <= '0;
            st_r  <= q_item.is_load ? S_LOAD : S_SCAN;
          end
        end
        S_LOAD: begin
          if (cur_r.idx_ok) valid_r[AW'(cur_r.entry_index)] <= cur_r.entry_enable;
          st_r <= S_FIN;
        end
        S_SCAN: begin
          if (valid_r[i_r]) begin
            st_r <= S_EVAL;
          end else if (is_last_i) begin
            st_r <= S_FIN;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        S_EVAL: begin
          if (match && is_hat && hcode != rd_r.out_value) begin
            hm_r[0] <= dxp ? cfg.left_mask : cfg.right_mask;
            hm_r[1] <= dxp ? cfg.right_mask : cfg.left_mask;
            hm_r[2] <= dyp ? cfg.up_mask : cfg.down_mask;
            hm_r[3] <= dyp ? cfg.down_mask : cfg.up_mask;
            hon_r   <= {dyp | dyn, 1'b0, dxp | dxn, 1'b0};
            step_r  <= 2'd0;
            st_r    <= S_HAT;
          end else if (is_last_i) begin
            st_r <= S_FIN;
          end else begin
            i_r  <= i_r + 1'b1;
            st_r <= S_SCAN;
          end
        end
        S_HAT: begin
          step_r <= step_r + 2'd1;
          if (step_r == 2'd3) begin
            if (is_last_i) begin
              st_r <= S_FIN;
            end else begin
              i_r  <= i_r + 1'b1;
              st_r <= S_SCAN;
            end
          end
        end
        S_FIN: begin
          out_last_r    <= 1'b1;
          out_kind_r    <= pend_v_r ? pend_kind_r : KIND_NONE;
          out_code_r    <= pend_v_r ? pend_code_r : 32'd0;
          out_pressed_r <= pend_v_r ? pend_pr_r : 1'b0;
          pend_v_r      <= 1'b0;
          cnt_r         <= '0;
          st_r          <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_player  = cfg.player;
  assign out_code    = out_code_r;
  assign out_pressed = out_pressed_r;
  assign out_last    = out_last_r;

`ifndef SYNTH
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RESULTS)) else $error("result count over limit");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> st_r == S_IDLE) else $error("last result mid-item");
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_NONE |-> out_last_r) else $error("empty result not last");
  a_eval_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_EVAL |-> $past(st_r) == S_SCAN) else $error("eval without table read");
`endif

endmodule

@@ hdl/input_event_remapper.sv @@
// ----------------------------------------------------------------------------
// input_event_remapper
// Maps raw input events through a table to held-mask changes and actions.
// ----------------------------------------------------------------------------
// Channel   Handshake          Payload
// input     start / busy       in_req_type .. in_target_code
// result    out_valid strobe   out_kind, out_player, out_code, out_pressed, out_last
// config    cfg_we             cfg_index, cfg_data
//
// A load writes one table entry. An event scans all N entries, one read per cycle
// save where a valid entry is evaluated or a changed hat runs its four mask steps.
// Reset is synchronous, active low; the map table holds no reset, valid bits clear.
// Up to two items queue in front; busy is high while the queue is full.
// Results are strobed one cycle each; the receiver cannot stall.
module input_event_remapper import iem_pkg::*; #(
  parameter int unsigned MAP_ENTRIES = MAP_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [5:0]  in_entry_index,
  input  logic        in_entry_enable,
  input  logic [31:0] in_source_button,
  input  logic [31:0] in_raw_value,
  input  logic [31:0] in_range_low,
  input  logic [31:0] in_range_high,
  input  logic [31:0] in_target_code,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_player,
  output logic [31:0] out_code,
  output logic        out_pressed,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t  cfg_r;
  logic  q_valid, q_pop;
  item_t q_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.player     <= 4'd1;
      cfg_r.hat_code   <= 32'hFFFF_FFFF;
      cfg_r.left_mask  <= 16'd1;
      cfg_r.right_mask <= 16'd2;
      cfg_r.up_mask    <= 16'd4;
      cfg_r.down_mask  <= 16'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PLAYER: cfg_r.player     <= cfg_data[3:0];
        REG_HAT:    cfg_r.hat_code   <= cfg_data;
        REG_LEFT:   cfg_r.left_mask  <= cfg_data[15:0];
        REG_RIGHT:  cfg_r.right_mask <= cfg_data[15:0];
        REG_UP:     cfg_r.up_mask    <= cfg_data[15:0];
        REG_DOWN:   cfg_r.down_mask  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  iem_front #(.MAP_ENTRIES(MAP_ENTRIES)) u_front (
    .clk, .rst_n, .start, .busy,
    .in_req_type, .in_entry_index, .in_entry_enable, .in_source_button,
    .in_raw_value, .in_range_low, .in_range_high, .in_target_code,
    .q_valid, .q_item, .q_pop
  );

  iem_back #(.MAP_ENTRIES(MAP_ENTRIES)) u_back (
    .clk, .rst_n, .cfg(cfg_r), .q_valid, .q_item, .q_pop,
    .out_valid, .out_kind, .out_player, .out_code, .out_pressed, .out_last
  );

endmodule
